>>> rtl/tpdc_pkg.sv
// package for the touch press duration classifier
// types, constants and helper functions shared by all rtl files; no dependencies
package tpdc_pkg;

    localparam int SENSOR_COUNT    = 8;
    localparam int ELECTRODE_COUNT = 12;

    localparam int IDX_W      = 3;
    localparam int MASK_W     = 12;
    localparam int TIMER_W    = 16;
    localparam int THR_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int POP_W      = 5;

    localparam int COUNTED_BITS = (ELECTRODE_COUNT < MASK_W) ? ELECTRODE_COUNT : MASK_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [THR_W-1:0]   MIN_ACTIVE_RESET = THR_W'(3);
    localparam logic [TIMER_W-1:0] SHORT_RESET      = TIMER_W'(50);
    localparam logic [TIMER_W-1:0] LONG_RESET       = TIMER_W'(1000);

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_ACTIVE = 2'd0,
        CFG_SHORT_MS   = 2'd1,
        CFG_LONG_MS    = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic              operation;
        logic [IDX_W-1:0]  sensor_index;
        logic [MASK_W-1:0] touched_mask;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] button_index;
        logic             long_press;
    } t_out_item;

    typedef struct packed {
        logic             is_tick;
        logic [IDX_W-1:0] sensor;
        logic             pressed;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [POP_W-1:0] count_touched(input logic [MASK_W-1:0] mask);
        logic [POP_W-1:0] n;
        n = '0;
        for (int k = 0; k < COUNTED_BITS; k++) begin
            n = n + POP_W'(mask[k]);
        end
        return n;
    endfunction

endpackage

>>> rtl/tpdc_front.sv
// front end: accepts items, counts touched electrodes and builds queue commands
// depends on tpdc_pkg
module tpdc_front (
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  tpdc_pkg::t_in_item     i_in_data,
    input  logic [tpdc_pkg::THR_W-1:0] i_min_active,
    input  tpdc_pkg::t_q_status    i_q_stat,
    output logic                   o_push,
    output tpdc_pkg::t_cmd         o_cmd
);
    import tpdc_pkg::*;

    logic             w_accept;
    logic             w_in_range;
    logic [POP_W-1:0] w_count;

    assign o_in_ready = !i_q_stat.full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_in_range = (POP_W'(i_in_data.sensor_index) < POP_W'(SENSOR_COUNT));
    assign w_count    = count_touched(i_in_data.touched_mask);

    always_comb begin
        o_cmd.is_tick = (i_in_data.operation == OP_TICK);
        o_cmd.sensor  = i_in_data.sensor_index;
        o_cmd.pressed = (w_count >= POP_W'(i_min_active));
        o_push        = w_accept && ((i_in_data.operation == OP_TICK) || w_in_range);
    end

endmodule

>>> rtl/tpdc_queue.sv
// short command queue between the front end and the back end
// depends on tpdc_pkg
module tpdc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  tpdc_pkg::t_cmd       i_cmd,
    input  logic                 i_pop,
    output tpdc_pkg::t_cmd       o_cmd,
    output tpdc_pkg::t_q_status  o_stat
);
    import tpdc_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    assign o_cmd        = r_slot[r_rd_ptr];
    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> rtl/tpdc_back.sv
// back end: per-sensor timers and pressed flags, release qualification, output register
// depends on tpdc_pkg
module tpdc_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tpdc_pkg::t_q_status          i_q_stat,
    input  tpdc_pkg::t_cmd               i_cmd,
    output logic                         o_pop,
    input  logic [tpdc_pkg::TIMER_W-1:0] i_short_ms,
    input  logic [tpdc_pkg::TIMER_W-1:0] i_long_ms,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output tpdc_pkg::t_out_item          o_out_data
);
    import tpdc_pkg::*;

    logic [TIMER_W-1:0] r_timer [SENSOR_COUNT];
    logic [TIMER_W-1:0] n_timer [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0] r_flag;
    logic [SENSOR_COUNT-1:0] n_flag;
    logic               r_out_valid;
    logic               n_out_valid;
    t_out_item          r_out;
    t_out_item          n_out;
    logic [TIMER_W-1:0] w_sel_timer;

    assign o_pop       = !i_q_stat.empty && (!r_out_valid || i_out_ready);
    assign w_sel_timer = r_timer[i_cmd.sensor];
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_timer     = r_timer;
        n_flag      = r_flag;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (o_pop) begin
            if (i_cmd.is_tick) begin
                for (int k = 0; k < SENSOR_COUNT; k++) begin
                    if (r_timer[k] != '1) begin
                        n_timer[k] = r_timer[k] + 1'b1;
                    end
                end
            end else if (i_cmd.pressed != r_flag[i_cmd.sensor]) begin
                n_timer[i_cmd.sensor] = '0;
                n_flag[i_cmd.sensor]  = i_cmd.pressed;
                if (!i_cmd.pressed && (w_sel_timer >= i_short_ms)) begin
                    n_out_valid        = 1'b1;
                    n_out.button_index = i_cmd.sensor;
                    n_out.long_press   = (w_sel_timer >= i_long_ms);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SENSOR_COUNT; k++) begin
                r_timer[k] <= '0;
            end
            r_flag      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_timer     <= n_timer;
            r_flag      <= n_flag;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

>>> rtl/touch_press_duration_classifier.sv
// Touch press qualifier for eight sensors. Each input transfer is either a millisecond tick,
// which advances every sensor timer (saturating at 65535), or a touch sample whose touched
// electrodes are counted against min_active_electrodes; a release after a press of at least
// short_press_ms ticks yields one result with the button index and a long-press flag.
// One item is accepted per clock cycle while the command queue is not full. With nothing stalled,
// an accepted sample's command is written into the four-entry command queue and is then
// classified into the output register, from which its result is presented on the output.
// The queue lets input transfers continue for up to four items while the output is stalled.
// Configuration writes are taken at once (ready is always high).
// top level; depends on tpdc_pkg, tpdc_front, tpdc_queue, tpdc_back
module touch_press_duration_classifier (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  tpdc_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output tpdc_pkg::t_out_item               o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tpdc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tpdc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tpdc_pkg::*;

    logic [THR_W-1:0]   r_min_active;
    logic [TIMER_W-1:0] r_short_ms;
    logic [TIMER_W-1:0] r_long_ms;

    logic      w_push;
    logic      w_pop;
    t_cmd      w_front_cmd;
    t_cmd      w_q_cmd;
    t_q_status w_q_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_active <= MIN_ACTIVE_RESET;
            r_short_ms   <= SHORT_RESET;
            r_long_ms    <= LONG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_MIN_ACTIVE: r_min_active <= i_cfg_data[THR_W-1:0];
                CFG_SHORT_MS:   r_short_ms   <= i_cfg_data[TIMER_W-1:0];
                CFG_LONG_MS:    r_long_ms    <= i_cfg_data[TIMER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tpdc_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_min_active (r_min_active),
        .i_q_stat     (w_q_stat),
        .o_push       (w_push),
        .o_cmd        (w_front_cmd)
    );

    tpdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_q_cmd),
        .o_stat  (w_q_stat)
    );

    tpdc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (w_q_stat),
        .i_cmd       (w_q_cmd),
        .o_pop       (w_pop),
        .i_short_ms  (r_short_ms),
        .i_long_ms   (r_long_ms),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_no_pop_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !w_pop)
        else $error("command popped while output stalled");

    a_result_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_pop))
        else $error("result without a popped command");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.empty |-> !w_pop)
        else $error("pop from empty queue");
`endif

endmodule
